[sv/pose_gesture_classifier_macros.svh]
// Assertion helpers for the gesture classifier.
// Each macro samples on clk and stays quiet while arst_n is low.
`ifndef POSE_GESTURE_CLASSIFIER_MACROS_SVH
`define POSE_GESTURE_CLASSIFIER_MACROS_SVH

// Same-cycle implication.
`define PGC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PGC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/pgc_pkg.sv]
`timescale 1ns / 1ps
package pgc_pkg;

	localparam int HISTORY_DEPTH = 5;
	localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

	localparam int COORD_W = 16;
	localparam int CONF_W = 8;
	localparam int KP_W = 2 * COORD_W + CONF_W;
	localparam int MOVE_W = 12;
	localparam int SQ_W = 2 * COORD_W;
	localparam int T2_W = 2 * MOVE_W;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_CONF_THR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RAISE_THR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MOVE_THR = 2'd2;

	localparam logic [CONF_W-1:0] CONF_THR_RST = 8'd128;
	localparam logic [COORD_W-1:0] RAISE_THR_RST = 16'd480;
	localparam logic [MOVE_W-1:0] MOVE_THR_RST = 12'd240;

	localparam logic ACTION_CLEAR = 1'b1;

	localparam logic [1:0] GC_STILL = 2'd0;
	localparam logic [1:0] GC_MOVING = 2'd1;
	localparam logic [1:0] GC_RAISE = 2'd2;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [CONF_W-1:0] conf;
	} kp_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} coord_t;

	// Decoded detection, as seen by the history and the motion stages.
	typedef struct packed {
		logic clear;
		logic raise;
		logic push;
		coord_t center;
	} front_t;

	// Item entering the motion pipeline.
	typedef struct packed {
		logic raise;
		logic check;
		coord_t center;
	} item_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [SLOT_W-1:0] oldest;
	} hist_stat_t;

endpackage

[sv/pgc_front.sv]
`timescale 1ns / 1ps
module pgc_front (
	input logic action,
	input logic [pgc_pkg::KP_W-1:0] left_shoulder,
	input logic [pgc_pkg::KP_W-1:0] right_shoulder,
	input logic [pgc_pkg::KP_W-1:0] left_wrist,
	input logic [pgc_pkg::KP_W-1:0] right_wrist,
	input logic [pgc_pkg::KP_W-1:0] left_hip,
	input logic [pgc_pkg::KP_W-1:0] right_hip,
	input logic [pgc_pkg::CONF_W-1:0] conf_thr,
	input logic [pgc_pkg::COORD_W-1:0] raise_thr,
	output pgc_pkg::front_t front
);
	import pgc_pkg::*;

	kp_t ls, rs, lw, rw, lh, rh;
	logic ls_ok, rs_ok, lw_ok, rw_ok, lh_ok, rh_ok;
	logic left_up, right_up;
	logic [COORD_W-1:0] left_rise, right_rise;
	logic [COORD_W:0] sum_x, sum_y;

	function automatic logic kp_ok(kp_t k, logic [CONF_W-1:0] thr);
		return (k.conf >= thr) && (k.x != '0) && (k.y != '0);
	endfunction

	assign ls = kp_t'(left_shoulder);
	assign rs = kp_t'(right_shoulder);
	assign lw = kp_t'(left_wrist);
	assign rw = kp_t'(right_wrist);
	assign lh = kp_t'(left_hip);
	assign rh = kp_t'(right_hip);

	assign ls_ok = kp_ok(ls, conf_thr);
	assign rs_ok = kp_ok(rs, conf_thr);
	assign lw_ok = kp_ok(lw, conf_thr);
	assign rw_ok = kp_ok(rw, conf_thr);
	assign lh_ok = kp_ok(lh, conf_thr);
	assign rh_ok = kp_ok(rh, conf_thr);

	// Wrist above shoulder means smaller y; a negative rise never counts.
	assign left_rise = ls.y - lw.y;
	assign right_rise = rs.y - rw.y;
	assign left_up = ls_ok && lw_ok && (ls.y > lw.y) && (left_rise > raise_thr);
	assign right_up = rs_ok && rw_ok && (rs.y > rw.y) && (right_rise > raise_thr);

	assign sum_x = {1'b0, lh.x} + {1'b0, rh.x};
	assign sum_y = {1'b0, lh.y} + {1'b0, rh.y};

	always_comb begin
		front.clear = (action == ACTION_CLEAR);
		front.raise = !front.clear && (left_up || right_up);
		front.push = !front.clear && !front.raise && (lh_ok || rh_ok);
		if (lh_ok && rh_ok) begin
			front.center.x = sum_x[COORD_W:1];
			front.center.y = sum_y[COORD_W:1];
		end else if (lh_ok) begin
			front.center.x = lh.x;
			front.center.y = lh.y;
		end else begin
			front.center.x = rh.x;
			front.center.y = rh.y;
		end
	end

endmodule

[sv/pgc_hist.sv]
`timescale 1ns / 1ps
module pgc_hist (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input pgc_pkg::front_t front,
	output pgc_pkg::coord_t oldest_rd,
	output logic check,
	output pgc_pkg::hist_stat_t stat
);
	import pgc_pkg::*;

	coord_t mem [HISTORY_DEPTH];
	coord_t rd_q;
	logic [CNT_W-1:0] count_q;
	logic [SLOT_W-1:0] oldest_q;
	logic [SLOT_W:0] wr_sum;
	logic [SLOT_W-1:0] wr_slot;
	logic [SLOT_W-1:0] oldest_inc;
	logic full;

	assign full = (count_q == CNT_W'(HISTORY_DEPTH));

	// Free slot follows the oldest by count; one wrap at most.
	assign wr_sum = {1'b0, oldest_q} + (SLOT_W + 1)'(count_q);
	always_comb begin
		if (full) begin
			wr_slot = oldest_q;
		end else if (wr_sum >= (SLOT_W + 1)'(HISTORY_DEPTH)) begin
			wr_slot = SLOT_W'(wr_sum - (SLOT_W + 1)'(HISTORY_DEPTH));
		end else begin
			wr_slot = wr_sum[SLOT_W-1:0];
		end
	end

	assign oldest_inc = (oldest_q == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : oldest_q + 1'b1;

	// Read-first port: an overwrite of the oldest slot still returns its old value.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= mem[oldest_q];
			if (front.push) begin
				mem[wr_slot] <= front.center;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			oldest_q <= '0;
		end else if (accept) begin
			if (front.clear) begin
				count_q <= '0;
				oldest_q <= '0;
			end else if (front.push) begin
				if (full) begin
					oldest_q <= oldest_inc;
				end else begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	assign oldest_rd = rd_q;
	assign check = front.push && (count_q >= CNT_W'(2));
	assign stat.count = count_q;
	assign stat.oldest = oldest_q;

endmodule

[sv/pgc_motion.sv]
`timescale 1ns / 1ps
module pgc_motion (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input pgc_pkg::item_t item,
	input pgc_pkg::coord_t oldest_rd,
	input logic [pgc_pkg::MOVE_W-1:0] move_thr,
	output logic take,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] gesture_class
);
	import pgc_pkg::*;

	logic v_s1, v_s2, valid_q;
	item_t item_s1;
	logic raise_s2, check_s2;
	logic [SQ_W-1:0] dx2_s2, dy2_s2;
	logic [T2_W-1:0] t2_q;
	logic [1:0] class_q;
	logic [COORD_W-1:0] dx, dy;
	logic [SQ_W:0] d2;
	logic load_o, load_s2;

	// Ready ripples back through the stages so bubbles close up.
	assign load_o = v_s2 && (!valid_q || out_ready);
	assign load_s2 = v_s1 && (!v_s2 || load_o);
	assign take = !v_s1 || load_s2;

	assign dx = (item_s1.center.x >= oldest_rd.x) ? item_s1.center.x - oldest_rd.x
	                                               : oldest_rd.x - item_s1.center.x;
	assign dy = (item_s1.center.y >= oldest_rd.y) ? item_s1.center.y - oldest_rd.y
	                                               : oldest_rd.y - item_s1.center.y;
	assign d2 = {1'b0, dx2_s2} + {1'b0, dy2_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (load_s2) begin
				v_s1 <= 1'b0;
			end
			if (load_s2) begin
				v_s2 <= 1'b1;
			end else if (load_o) begin
				v_s2 <= 1'b0;
			end
			if (load_o) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		t2_q <= T2_W'(move_thr) * T2_W'(move_thr);
		if (accept) begin
			item_s1 <= item;
		end
		if (load_s2) begin
			raise_s2 <= item_s1.raise;
			check_s2 <= item_s1.check;
			dx2_s2 <= SQ_W'(dx) * SQ_W'(dx);
			dy2_s2 <= SQ_W'(dy) * SQ_W'(dy);
		end
		if (load_o) begin
			if (raise_s2) begin
				class_q <= GC_RAISE;
			end else if (check_s2 && (d2 > (SQ_W + 1)'(t2_q))) begin
				class_q <= GC_MOVING;
			end else begin
				class_q <= GC_STILL;
			end
		end
	end

	assign out_valid = valid_q;
	assign gesture_class = class_q;

endmodule

[sv/pose_gesture_classifier.sv]
`timescale 1ns / 1ps
// Channel     | Handshake               | Payload
// ------------+-------------------------+---------------------------------------
// input       | in_valid / in_ready     | action, six packed keypoints (40 bits)
// result      | out_valid / out_ready   | gesture_class (2 bits)
// config      | cfg_wr_en               | cfg_index (2 bits), cfg_data (16 bits)
//
// One detection per cycle unless results stall; stages s1, s2 and the output register.
// The history ring is one memory with at most one write and one read per beat; the
// oldest center is read on the accept edge while the new center is written on that edge.
// Reset clears the ring pointers and presets the thresholds at once; no clearing pass is needed.
// A stalled result holds in the output register while up to two more beats are taken.
`include "pose_gesture_classifier_macros.svh"
module pose_gesture_classifier (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic action,
	input logic [pgc_pkg::KP_W-1:0] left_shoulder,
	input logic [pgc_pkg::KP_W-1:0] right_shoulder,
	input logic [pgc_pkg::KP_W-1:0] left_wrist,
	input logic [pgc_pkg::KP_W-1:0] right_wrist,
	input logic [pgc_pkg::KP_W-1:0] left_hip,
	input logic [pgc_pkg::KP_W-1:0] right_hip,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] gesture_class,
	input logic cfg_wr_en,
	input logic [pgc_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [pgc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pgc_pkg::*;

	logic [CONF_W-1:0] conf_thr_q;
	logic [COORD_W-1:0] raise_thr_q;
	logic [MOVE_W-1:0] move_thr_q;
	front_t front;
	coord_t oldest_rd;
	hist_stat_t hist_stat;
	item_t item;
	logic check;
	logic take;
	logic accept;

	// Threshold registers; writes to unused indexes drop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conf_thr_q <= CONF_THR_RST;
			raise_thr_q <= RAISE_THR_RST;
			move_thr_q <= MOVE_THR_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_CONF_THR: conf_thr_q <= cfg_data[CONF_W-1:0];
				CFG_RAISE_THR: raise_thr_q <= cfg_data[COORD_W-1:0];
				CFG_MOVE_THR: move_thr_q <= cfg_data[MOVE_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_ready = take;
	assign accept = in_valid && take;

	// Decode keypoints: validity, raised hand, hip center.
	pgc_front u_front (
		.action(action),
		.left_shoulder(left_shoulder),
		.right_shoulder(right_shoulder),
		.left_wrist(left_wrist),
		.right_wrist(right_wrist),
		.left_hip(left_hip),
		.right_hip(right_hip),
		.conf_thr(conf_thr_q),
		.raise_thr(raise_thr_q),
		.front(front)
	);

	// Ring of past centers; the oldest one comes back registered, aligned with stage one.
	pgc_hist u_hist (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.front(front),
		.oldest_rd(oldest_rd),
		.check(check),
		.stat(hist_stat)
	);

	assign item.raise = front.raise;
	assign item.check = check;
	assign item.center = front.center;

	// Squared distance against the threshold, then the output register.
	pgc_motion u_motion (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.item(item),
		.oldest_rd(oldest_rd),
		.move_thr(move_thr_q),
		.take(take),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.gesture_class(gesture_class)
	);

	`PGC_ASSERT_NOW(a_count_bound, 1'b1, hist_stat.count <= CNT_W'(HISTORY_DEPTH), "history count past depth")
	`PGC_ASSERT_NEXT(a_clear_empties, accept && (action == ACTION_CLEAR), (hist_stat.count == '0) && (hist_stat.oldest == '0), "clear left history behind")
	`PGC_ASSERT_NOW(a_class_code, out_valid, (gesture_class == GC_STILL) || (gesture_class == GC_MOVING) || (gesture_class == GC_RAISE), "bad gesture code")

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
module tb;
	import pgc_pkg::*;

	// Register index that decodes to nothing; writes to it must not disturb the thresholds.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	// One detection beat as it crosses the input channel.
	typedef struct packed {
		logic act;
		kp_t ls;
		kp_t rs;
		kp_t lw;
		kp_t rw;
		kp_t lh;
		kp_t rh;
	} detection_t;

	// Scoreboard: mirrors the thresholds and the hip-center ring, turns every accepted
	// detection into the gesture class it must produce and holds those in beat order.
	class gesture_scoreboard;
		typedef struct {
			logic [1:0] gc;
			int beat;
		} awaited_t;

		logic [CONF_W-1:0] conf_thr;
		logic [COORD_W-1:0] raise_thr;
		logic [MOVE_W-1:0] move_thr;
		logic [COORD_W-1:0] ring_x[HISTORY_DEPTH];
		logic [COORD_W-1:0] ring_y[HISTORY_DEPTH];
		int unsigned ring_count;
		int unsigned ring_oldest;
		awaited_t awaited[$];
		int beats;
		int errors;

		function new();
			conf_thr = CONF_THR_RST;
			raise_thr = RAISE_THR_RST;
			move_thr = MOVE_THR_RST;
			ring_count = 0;
			ring_oldest = 0;
			beats = 0;
			errors = 0;
		endfunction

		// Mask to the register width; unknown indexes fall through untouched.
		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_CONF_THR: conf_thr = val[CONF_W-1:0];
				CFG_RAISE_THR: raise_thr = val;
				CFG_MOVE_THR: move_thr = val[MOVE_W-1:0];
				default: ;
			endcase
		endfunction

		function bit usable(kp_t k);
			return k.conf >= conf_thr && k.x != '0 && k.y != '0;
		endfunction

		// Image y grows downward, so a raised wrist sits above (smaller y than) its shoulder.
		function bit hand_up(kp_t sh, kp_t wr);
			int rise;
			if (!usable(sh) || !usable(wr))
				return 1'b0;
			rise = int'(sh.y) - int'(wr.y);
			return rise > int'(raise_thr);
		endfunction

		function logic [1:0] classify(detection_t d);
			logic lv, rv;
			logic [COORD_W:0] sum_x, sum_y;
			logic [COORD_W-1:0] cx, cy;
			logic [COORD_W-1:0] dx, dy;
			int unsigned slot;
			logic [63:0] d2, t2;
			logic [1:0] gc;
			if (d.act == ACTION_CLEAR) begin
				ring_count = 0;
				ring_oldest = 0;
				return GC_STILL;
			end
			if (hand_up(d.ls, d.lw) || hand_up(d.rs, d.rw))
				return GC_RAISE;
			lv = usable(d.lh);
			rv = usable(d.rh);
			if (lv && rv) begin
				sum_x = {1'b0, d.lh.x} + {1'b0, d.rh.x};
				sum_y = {1'b0, d.lh.y} + {1'b0, d.rh.y};
				cx = sum_x[COORD_W:1];
				cy = sum_y[COORD_W:1];
			end else if (lv) begin
				cx = d.lh.x;
				cy = d.lh.y;
			end else if (rv) begin
				cx = d.rh.x;
				cy = d.rh.y;
			end else begin
				return GC_STILL;
			end
			gc = GC_STILL;
			if (ring_count >= 2) begin
				slot = ring_oldest;
				if (cx >= ring_x[slot])
					dx = cx - ring_x[slot];
				else
					dx = ring_x[slot] - cx;
				if (cy >= ring_y[slot])
					dy = cy - ring_y[slot];
				else
					dy = ring_y[slot] - cy;
				d2 = 64'(dx) * 64'(dx) + 64'(dy) * 64'(dy);
				t2 = 64'(move_thr) * 64'(move_thr);
				if (d2 > t2)
					gc = GC_MOVING;
			end
			// Append while there is room, else overwrite the oldest and advance past it.
			if (ring_count < HISTORY_DEPTH) begin
				slot = (ring_oldest + ring_count) % HISTORY_DEPTH;
				ring_count++;
			end else begin
				slot = ring_oldest;
				ring_oldest = (slot + 1) % HISTORY_DEPTH;
			end
			ring_x[slot] = cx;
			ring_y[slot] = cy;
			return gc;
		endfunction

		function void note_beat(detection_t d);
			awaited_t a;
			a.gc = classify(d);
			a.beat = beats;
			awaited.insert(awaited.size(), a);
			beats++;
		endfunction

		task report(string msg);
			$display("[%0t] gesture check: %s", $time, msg);
			errors++;
		endtask

		task check_result(logic [1:0] gc);
			awaited_t a;
			if (awaited.size() == 0) begin
				report($sformatf("result %0d arrived with nothing outstanding", gc));
			end else begin
				a = awaited[0];
				awaited.delete(0);
				if (gc !== a.gc)
					report($sformatf("beat %0d: gesture_class %0d, want %0d", a.beat, gc, a.gc));
			end
		endtask

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic action;
	logic [KP_W-1:0] left_shoulder;
	logic [KP_W-1:0] right_shoulder;
	logic [KP_W-1:0] left_wrist;
	logic [KP_W-1:0] right_wrist;
	logic [KP_W-1:0] left_hip;
	logic [KP_W-1:0] right_hip;
	logic out_valid;
	logic out_ready;
	logic [1:0] gesture_class;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	gesture_scoreboard sb = new();

	int sent = 0;       // beats accepted on the input side
	int hold_off = 0;   // one-shot long stall request for the result side
	int trk_x = 32768;  // wandering hip center of the synthetic person
	int trk_y = 30000;

	pose_gesture_classifier DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.left_shoulder(left_shoulder),
		.right_shoulder(right_shoulder),
		.left_wrist(left_wrist),
		.right_wrist(right_wrist),
		.left_hip(left_hip),
		.right_hip(right_hip),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.gesture_class(gesture_class),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#1_000_000;
		$display("pose_gesture_classifier regression: fail");
		$finish;
	end

	// Check every result beat; values read here are the ones in effect at the edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(gesture_class);
	end

	function logic [COORD_W-1:0] clip16(int v);
		if (v < 0)
			return '0;
		if (v > 65535)
			return '1;
		return v[COORD_W-1:0];
	endfunction

	function kp_t mk_kp(int x, int y, int c);
		kp_t k;
		k.x = clip16(x);
		k.y = clip16(y);
		k.conf = (c > 255) ? 8'hFF : ((c < 0) ? 8'h00 : c[CONF_W-1:0]);
		return k;
	endfunction

	// Fully random keypoint: every bit of every field gets exercised.
	function kp_t rand_kp();
		logic [KP_W-1:0] v;
		v[31:0] = $urandom;
		v[KP_W-1:32] = 8'($urandom_range(0, 255));
		return kp_t'(v);
	endfunction

	// Coordinate that drops to zero now and then, which voids the keypoint.
	function int coord(int v);
		if ($urandom_range(0, 39) == 0)
			return 0;
		return int'(clip16(v));
	endfunction

	// Confidence clustered around the live threshold, including the exact value.
	function int pick_conf();
		int r;
		int thr;
		r = $urandom_range(0, 99);
		thr = int'(sb.conf_thr);
		if (r < 70)
			return $urandom_range(thr, 255);
		if (r < 85 && thr > 0)
			return $urandom_range(0, thr - 1);
		if (r < 92)
			return thr;
		return $urandom_range(0, 255);
	endfunction

	function int pick_wrist_y(int sy);
		int r;
		int jitter;
		r = $urandom_range(0, 99);
		jitter = $urandom_range(0, 6);
		if (r < 70)
			return sy + $urandom_range(0, 3000);
		if (r < 90)
			return sy - int'(sb.raise_thr) + jitter - 3;
		return sy - int'(sb.raise_thr) - int'($urandom_range(1, 2000));
	endfunction

	// Standing person with fixed shoulders and lowered wrists; only the hips vary.
	function detection_t person(int lx, int ly, int lc, int rx, int ry, int rc);
		detection_t d;
		d.act = ~ACTION_CLEAR;
		d.ls = mk_kp(1000, 2000, 200);
		d.rs = mk_kp(1400, 2000, 200);
		d.lw = mk_kp(900, 3000, 200);
		d.rw = mk_kp(1500, 3000, 200);
		d.lh = mk_kp(lx, ly, lc);
		d.rh = mk_kp(rx, ry, rc);
		return d;
	endfunction

	// Mostly a person walking about with a random stride, some clears and some noise.
	task gen_detection(output detection_t d);
		int r, mag, jig, sw, sy;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			d.act = (r < 4) ? ACTION_CLEAR : ~ACTION_CLEAR;
			d.ls = rand_kp();
			d.rs = rand_kp();
			d.lw = rand_kp();
			d.rw = rand_kp();
			d.lh = rand_kp();
			d.rh = rand_kp();
		end else begin
			case ($urandom_range(0, 3))
				0: mag = int'(sb.move_thr) / 4;
				1: mag = int'(sb.move_thr) + 2;
				2: mag = 2 * int'(sb.move_thr) + 16;
				default: mag = 8;
			endcase
			jig = $urandom_range(0, 2 * mag);
			trk_x = trk_x + jig - mag;
			jig = $urandom_range(0, 2 * mag);
			trk_y = trk_y + jig - mag;
			if (trk_x < 4000 || trk_x > 61000)
				trk_x = 32768;
			if (trk_y < 12000 || trk_y > 61000)
				trk_y = 30000;
			sw = $urandom_range(0, 300);
			sy = trk_y - int'($urandom_range(2000, 8000));
			d.act = ~ACTION_CLEAR;
			d.lh = mk_kp(coord(trk_x - sw), coord(trk_y + int'($urandom_range(0, 3))),
				pick_conf());
			d.rh = mk_kp(coord(trk_x + sw + int'($urandom_range(0, 1))), coord(trk_y),
				pick_conf());
			d.ls = mk_kp(coord(trk_x - sw - 100), coord(sy), pick_conf());
			d.rs = mk_kp(coord(trk_x + sw + 100), coord(sy), pick_conf());
			d.lw = mk_kp(coord(trk_x - sw - 150), coord(pick_wrist_y(sy)), pick_conf());
			d.rw = mk_kp(coord(trk_x + sw + 150), coord(pick_wrist_y(sy)), pick_conf());
		end
	endtask

	// Offer one beat after a random gap; leave valid high so a zero gap next time
	// chains straight on without dropping it.
	task send_detection(detection_t d);
		int gap;
		gap = (sent % 60 < 18) ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= d.act;
		left_shoulder <= d.ls;
		right_shoulder <= d.rs;
		left_wrist <= d.lw;
		right_wrist <= d.rw;
		left_hip <= d.lh;
		right_hip <= d.rh;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_beat(d);
		sent++;
	endtask

	// Result side: random stalls, bursts with none, and one long hold-off on request.
	task receive_results();
		int stall;
		int taken;
		taken = 0;
		forever begin
			if (hold_off > 0) begin
				stall = hold_off;
				hold_off = 0;
			end else begin
				stall = (taken % 45 < 12) ? 0 : $urandom_range(0, 18);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			taken++;
		end
	endtask

	// Wait until every expected class has come back, then let the pipe go quiet.
	task drain();
		int waited;
		waited = 0;
		while (sb.pending() != 0 && waited < 4000) begin
			@(posedge clk);
			waited++;
		end
		if (sb.pending() != 0) begin
			sb.report($sformatf("%0d results never arrived", sb.pending()));
			sb.awaited.delete();
		end
		repeat (8) @(posedge clk);
	endtask

	task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task configure(logic [CFG_DATA_W-1:0] conf, logic [CFG_DATA_W-1:0] raise,
		logic [CFG_DATA_W-1:0] move);
		write_reg(CFG_CONF_THR, conf);
		write_reg(CFG_RAISE_THR, raise);
		write_reg(CFG_MOVE_THR, move);
		cfg_wr_en <= 1'b0;
	endtask

	task run_phase(int n);
		detection_t d;
		repeat (n) begin
			gen_detection(d);
			send_detection(d);
		end
		in_valid <= 1'b0;
		drain();
	endtask

	// Hand-picked detections under the reset thresholds (conf 128, raise 480, move 240).
	task directed_checks();
		detection_t d;
		// clear carrying an all-ones payload
		d = '1;
		d.act = ACTION_CLEAR;
		send_detection(d);
		// all-zero keypoints: nothing valid, no hip
		d = '0;
		d.act = ~ACTION_CLEAR;
		send_detection(d);
		// all-ones keypoints: hip center at the far corner
		d = '1;
		d.act = ~ACTION_CLEAR;
		send_detection(d);
		// second center, then a third that is far from the corner
		send_detection(person(1100, 4000, 200, 1300, 4000, 200));
		send_detection(person(1100, 4000, 200, 1300, 4000, 200));
		d = '0;
		d.act = ACTION_CLEAR;
		send_detection(d);
		// left hip only (right just under threshold), then right hip only (left x zero)
		send_detection(person(1100, 4000, 200, 1300, 4000, 127));
		send_detection(person(0, 4000, 200, 1300, 4000, 200));
		// both hips with odd sums: truncate the average
		send_detection(person(1101, 4001, 200, 1300, 4000, 200));
		// exactly the move distance at exactly the confidence threshold, then one over
		send_detection(person(1340, 4000, 128, 1340, 4000, 128));
		send_detection(person(1341, 4000, 200, 1341, 4000, 200));
		// ring is full: overwrite the oldest, then compare past the wrap
		send_detection(person(1100, 4000, 200, 1100, 4000, 200));
		send_detection(person(1300, 4241, 200, 1300, 4241, 200));
		// left hand one above the raise height, then exactly at it
		d = person(1200, 4000, 200, 1200, 4000, 200);
		d.lw.y = 16'd1519;
		send_detection(d);
		d.lw.y = 16'd1520;
		send_detection(d);
		// right hand raised
		d = person(1200, 4000, 200, 1200, 4000, 200);
		d.rw.y = 16'd1519;
		send_detection(d);
		// raised wrist too weak, then raised wrist paired with a shoulder with x zero
		d.rw.y = 16'd3000;
		d.lw.y = 16'd1519;
		d.lw.conf = 8'd127;
		send_detection(d);
		d.lw.conf = 8'd200;
		d.ls.x = '0;
		send_detection(d);
		// wrist far below shoulder: large negative rise
		d = person(1200, 4000, 200, 1200, 4000, 200);
		d.ls.y = 16'd16;
		d.lw.y = 16'hFFFF;
		send_detection(d);
		// no valid hip at all, then left hip voided by y zero
		send_detection(person(1200, 4000, 0, 1200, 4000, 0));
		send_detection(person(1200, 0, 200, 1250, 4000, 200));
		// clear with zero payload and start over
		d = '0;
		d.act = ACTION_CLEAR;
		send_detection(d);
		send_detection(person(1200, 4000, 255, 1200, 4000, 255));
		in_valid <= 1'b0;
		drain();
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		action <= 1'b0;
		left_shoulder <= '0;
		right_shoulder <= '0;
		left_wrist <= '0;
		right_wrist <= '0;
		left_hip <= '0;
		right_hip <= '0;
		out_ready <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		fork
			receive_results();
		join_none
		@(posedge clk);

		directed_checks();

		// Lowest thresholds; poke the unused index too. Hold the result side off long
		// enough for the pipe to fill and push back on the input.
		write_reg(CFG_UNUSED, 16'hFFFF);
		configure(16'd0, 16'd0, 16'd0);
		hold_off = 150;
		run_phase(110);

		// Highest thresholds: only full confidence counts, raise is out of reach.
		configure(16'd255, 16'hFFFF, 16'd4095);
		run_phase(110);

		// Upper data bits set on the narrow registers: drop them.
		configure(16'hA540, 16'd96, 16'hF0C8);
		run_phase(110);

		configure(16'($urandom), 16'($urandom_range(0, 2000)), 16'($urandom));
		run_phase(110);

		configure(16'(CONF_THR_RST), 16'(RAISE_THR_RST), 16'(MOVE_THR_RST));
		run_phase(110);

		if (sb.errors == 0) begin
			$display("pose_gesture_classifier regression: pass");
		end else begin
			$display("pose_gesture_classifier regression: fail");
		end
		$finish;
	end
endmodule
